// File: rtl/core/gctp_pkg.sv
// Shared types and constants of the grid coordinate text parser.
// Depends on nothing; every other file of the block imports it.
package gctp_pkg;

   localparam int unsigned COORD_W     = 24;
   localparam int unsigned RES_W       = 10;
   localparam int unsigned MIN_DIGITS  = 4;
   localparam int unsigned SCALE_STEPS = 3;

   localparam logic [COORD_W-1:0] SCALE_TARGET = COORD_W'(1000000);

   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_NINE  = 8'd57;
   localparam logic [7:0] CHAR_TAB   = 8'd9;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_SPACE = 8'd32;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_SYNTAX = 2'd1,
      STATUS_RANGE  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CSR_NORTH_LOW  = 3'd0,
      CSR_NORTH_HIGH = 3'd1,
      CSR_A_EAST_LOW  = 3'd2,
      CSR_A_EAST_HIGH = 3'd3,
      CSR_B_EAST_LOW  = 3'd4,
      CSR_B_EAST_HIGH = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [COORD_W-1:0] north_low;
      logic [COORD_W-1:0] north_high;
      logic [COORD_W-1:0] a_east_low;
      logic [COORD_W-1:0] a_east_high;
      logic [COORD_W-1:0] b_east_low;
      logic [COORD_W-1:0] b_east_high;
   } cfg_type;

   // Resolution in metres for a number of decade steps; unity is reported as 5.
   function automatic logic [RES_W-1:0] resolution_of(input logic [SCALE_STEPS-1:0] steps);
      logic [RES_W-1:0] res;
      unique case (steps)
         3'd0:    res = RES_W'(5);
         3'd1:    res = RES_W'(10);
         3'd2:    res = RES_W'(100);
         3'd3:    res = RES_W'(1000);
         default: res = RES_W'(1023);
      endcase
      return res;
   endfunction

endpackage

// File: rtl/core/gctp_chan_if.sv
// Valid/ready channels of the grid coordinate text parser: text in, result out.
// Depends on gctp_pkg for the field widths.
interface gctp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_char;
   logic       is_final;

   modport source (output valid, output text_char, output is_final, input ready);
   modport sink   (input valid, input text_char, input is_final, output ready);
endinterface

interface gctp_rsp_if import gctp_pkg::*;;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [COORD_W-1:0] north_out;
   logic [COORD_W-1:0] east_out;
   logic [RES_W-1:0]   resolution_out;

   modport source (output valid, output status, output north_out, output east_out,
                   output resolution_out, input ready);
   modport sink   (input valid, input status, input north_out, input east_out,
                   input resolution_out, output ready);
endinterface

// File: rtl/core/gctp_front.sv
// Front end: takes one text word a cycle unless the queue is full, checks the syntax
// and builds both values. On the final word it pushes one job into the queue. Depends on gctp_pkg.
module gctp_front import gctp_pkg::*; #(
   parameter int unsigned MAX_DIGITS = 7,
   parameter int unsigned ACC_W      = 24
) (
   input  logic             clock,
   input  logic             reset,
   gctp_req_if.sink         req,
   input  logic             job_full,
   output logic             job_push,
   output logic [2*ACC_W:0] job_data
);

   localparam int unsigned RUN_W = $clog2(MAX_DIGITS + 1);

   typedef enum logic [4:0] {
      PH_LEAD  = 5'b00001,
      PH_NORTH = 5'b00010,
      PH_SEP   = 5'b00100,
      PH_EAST  = 5'b01000,
      PH_TRAIL = 5'b10000
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [RUN_W-1:0]   run_ff, run_in;
   logic [ACC_W-1:0]   north_ff, north_in;
   logic [ACC_W-1:0]   east_ff, east_in;
   logic               bad_ff, bad_in;

   phase_type          ph_nx;
   logic [RUN_W-1:0]   run_nx;
   logic [ACC_W-1:0]   north_nx, east_nx;
   logic               bad_nx;
   logic               is_ws, is_dig, take, job_ok;
   logic [3:0]         digit;
   logic [ACC_W-1:0]   acc_sel, acc_add;

   assign req.ready = !job_full;
   assign take      = req.valid && !job_full;

   assign is_ws  = (req.text_char >= CHAR_TAB && req.text_char <= CHAR_CR)
                   || req.text_char == CHAR_SPACE;
   assign is_dig = req.text_char >= CHAR_ZERO && req.text_char <= CHAR_NINE;
   assign digit  = req.text_char[3:0];

   // Digit goes to north while leading or in the north run, else to east.
   assign acc_sel = (phase_ff == PH_LEAD || phase_ff == PH_NORTH) ? north_ff : east_ff;
   assign acc_add = (acc_sel << 3) + (acc_sel << 1) + ACC_W'(digit);

   always_comb begin
      ph_nx    = phase_ff;
      run_nx   = run_ff;
      north_nx = north_ff;
      east_nx  = east_ff;
      bad_nx   = bad_ff;
      if (!bad_ff) begin
         unique case (phase_ff)
            PH_LEAD, PH_SEP: begin
               if (is_dig) begin
                  run_nx = RUN_W'(1);
                  if (phase_ff == PH_LEAD) begin
                     ph_nx    = PH_NORTH;
                     north_nx = acc_add;
                  end else begin
                     ph_nx   = PH_EAST;
                     east_nx = acc_add;
                  end
               end else if (!is_ws) begin
                  bad_nx = 1'b1;
               end
            end
            PH_NORTH, PH_EAST: begin
               if (is_dig) begin
                  if (run_ff >= RUN_W'(MAX_DIGITS)) begin
                     bad_nx = 1'b1;
                  end else begin
                     run_nx = run_ff + RUN_W'(1);
                     if (phase_ff == PH_NORTH) begin
                        north_nx = acc_add;
                     end else begin
                        east_nx = acc_add;
                     end
                  end
               end else if (is_ws && run_ff >= RUN_W'(MIN_DIGITS)) begin
                  ph_nx = (phase_ff == PH_NORTH) ? PH_SEP : PH_TRAIL;
               end else begin
                  bad_nx = 1'b1;
               end
            end
            PH_TRAIL: begin
               if (!is_ws) begin
                  bad_nx = 1'b1;
               end
            end
            default: bad_nx = 1'b1;
         endcase
      end
   end

   assign job_ok = !bad_nx && north_nx != '0
                   && ((ph_nx == PH_EAST && run_nx >= RUN_W'(MIN_DIGITS)) || ph_nx == PH_TRAIL);

   assign job_push = take && req.is_final;
   assign job_data = {job_ok, north_nx, east_nx};

   always_comb begin
      phase_in = phase_ff;
      run_in   = run_ff;
      north_in = north_ff;
      east_in  = east_ff;
      bad_in   = bad_ff;
      if (take) begin
         if (req.is_final) begin
            phase_in = PH_LEAD;
            run_in   = '0;
            north_in = '0;
            east_in  = '0;
            bad_in   = 1'b0;
         end else begin
            phase_in = ph_nx;
            run_in   = run_nx;
            north_in = north_nx;
            east_in  = east_nx;
            bad_in   = bad_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEAD;
         run_ff   <= '0;
         north_ff <= '0;
         east_ff  <= '0;
         bad_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         run_ff   <= run_in;
         north_ff <= north_in;
         east_ff  <= east_in;
         bad_ff   <= bad_in;
      end
   end

endmodule

// File: rtl/core/gctp_queue.sv
// Short job queue between the parser front end and the scaling back end.
// Register storage, one push a cycle while not full, one pop while not empty. Depends on gctp_pkg.
module gctp_queue import gctp_pkg::*; #(
   parameter int unsigned WIDTH = 49,
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = count_ff == CNT_W'(DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/core/gctp_back.sv
// Back end: scales north to seven digits one decade a cycle, east alongside,
// checks the grid ranges and holds the result word. Depends on gctp_pkg.
module gctp_back import gctp_pkg::*; #(
   parameter int unsigned ACC_W = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             job_empty,
   input  logic [2*ACC_W:0] job_data,
   output logic             job_pop,
   gctp_rsp_if.source       rsp
);

   localparam int unsigned VAL_W = (ACC_W > COORD_W) ? ACC_W : COORD_W;
   localparam logic [VAL_W:0] EAST_LIMIT = (VAL_W + 1)'(1) << COORD_W;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCALE = 3'b010,
      ST_EMIT  = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic                   ok_ff, ok_in;
   logic [VAL_W-1:0]       north_ff, north_in;
   logic [COORD_W-1:0]     east_ff, east_in;
   logic                   east_big_ff, east_big_in;
   logic [SCALE_STEPS-1:0] steps_ff, steps_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic [COORD_W-1:0]     rsp_north_ff, rsp_north_in;
   logic [COORD_W-1:0]     rsp_east_ff, rsp_east_in;
   logic [RES_W-1:0]       rsp_res_ff, rsp_res_in;

   logic                   job_ok;
   logic [ACC_W-1:0]       job_north, job_east;
   logic [VAL_W-1:0]       east_ext;
   logic                   need_scale, out_free, hit;
   logic [COORD_W+3:0]     east_x10;
   logic [VAL_W+3:0]       north_x10;
   logic                   north_in_range, a_hit, b_hit;

   assign {job_ok, job_north, job_east} = job_data;
   assign east_ext  = VAL_W'(job_east);

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign job_pop   = state_ff == ST_IDLE && !job_empty;
   assign need_scale = north_ff < VAL_W'(SCALE_TARGET);

   assign north_x10 = ((VAL_W + 4)'(north_ff) << 3) + ((VAL_W + 4)'(north_ff) << 1);
   assign east_x10  = ((COORD_W + 4)'(east_ff) << 3) + ((COORD_W + 4)'(east_ff) << 1);

   // East beyond 24 bits cannot fall in any window; keep only a sticky flag.
   assign north_in_range = north_ff >= VAL_W'(cfg.north_low)
                           && north_ff < VAL_W'(cfg.north_high);
   assign a_hit = !east_big_ff && east_ff >= cfg.a_east_low && east_ff < cfg.a_east_high;
   assign b_hit = !east_big_ff && steps_ff == '0
                  && east_ff >= cfg.b_east_low && east_ff < cfg.b_east_high;
   assign hit   = north_in_range && (a_hit || b_hit);

   always_comb begin
      state_in    = state_ff;
      ok_in       = ok_ff;
      north_in    = north_ff;
      east_in     = east_ff;
      east_big_in = east_big_ff;
      steps_in    = steps_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_north_in  = rsp_north_ff;
      rsp_east_in   = rsp_east_ff;
      rsp_res_in    = rsp_res_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!job_empty) begin
               ok_in       = job_ok;
               north_in    = VAL_W'(job_north);
               east_in     = east_ext[COORD_W-1:0];
               east_big_in = {1'b0, east_ext} >= EAST_LIMIT;
               steps_in    = '0;
               state_in    = job_ok ? ST_SCALE : ST_EMIT;
            end
         end
         ST_SCALE: begin
            if (need_scale) begin
               north_in    = north_x10[VAL_W-1:0];
               east_in     = east_x10[COORD_W-1:0];
               east_big_in = east_big_ff || east_x10[COORD_W+3:COORD_W] != '0;
               steps_in    = steps_ff + SCALE_STEPS'(1);
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (!ok_ff) begin
                  rsp_status_in = STATUS_SYNTAX;
                  rsp_north_in  = '0;
                  rsp_east_in   = '0;
                  rsp_res_in    = RES_W'(1);
               end else if (hit) begin
                  rsp_status_in = STATUS_OK;
                  rsp_north_in  = north_ff[COORD_W-1:0];
                  rsp_east_in   = east_ff;
                  rsp_res_in    = resolution_of(steps_ff);
               end else begin
                  rsp_status_in = STATUS_RANGE;
                  rsp_north_in  = '0;
                  rsp_east_in   = '0;
                  rsp_res_in    = resolution_of(steps_ff);
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.status         = rsp_status_ff;
   assign rsp.north_out      = rsp_north_ff;
   assign rsp.east_out       = rsp_east_ff;
   assign rsp.resolution_out = rsp_res_ff;

   always_ff @(posedge clock) begin
      ok_ff         <= ok_in;
      north_ff      <= north_in;
      east_ff       <= east_in;
      east_big_ff   <= east_big_in;
      steps_ff      <= steps_in;
      rsp_status_ff <= rsp_status_in;
      rsp_north_ff  <= rsp_north_in;
      rsp_east_ff   <= rsp_east_in;
      rsp_res_ff    <= rsp_res_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/core/grid_coordinate_text_parser.sv
// Grid coordinate text parser: top level with the range registers.
// Depends on gctp_pkg, gctp_chan_if, gctp_front, gctp_queue and gctp_back.
//
// The req channel carries one text character per word with a final flag; the
// rsp channel returns one result word per text, on the word marked final.
// The front end takes a character every cycle while the queue is not full.
// After the final character the job waits in a two-entry queue; the back
// end pops it when idle, multiplies north (and east) by ten once a cycle
// in its scale state until north has seven digits, then in its emit state
// writes the output register once that register is free. A syntax error
// skips the scale state. The back end pops no new job until it has
// written the result of the last one, so short texts from a fast source
// fill the queue and req.ready drops.
// While the receiver stalls, the result is held in the output register and
// the front end keeps parsing until the queue is full.
// Reset (synchronous) clears the parser, the queue and the output valid and
// loads the range registers with their default bounds. The csr port writes
// one 24-bit bound per cycle by index; unknown indexes are ignored.
module grid_coordinate_text_parser import gctp_pkg::*; #(
   parameter int unsigned MAX_DIGITS = 7
) (
   input  logic               clock,
   input  logic               reset,
   gctp_req_if.sink           req_ch,
   gctp_rsp_if.source         rsp_ch,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [COORD_W-1:0] csr_wdata
);

   localparam int unsigned ACC_W = $clog2(10 ** MAX_DIGITS);
   localparam int unsigned JOB_W = 2 * ACC_W + 1;

   cfg_type          cfg_ff, cfg_in;
   logic             job_push, job_pop, job_full, job_empty;
   logic [JOB_W-1:0] job_in_data, job_out_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_NORTH_LOW:   cfg_in.north_low   = csr_wdata;
            CSR_NORTH_HIGH:  cfg_in.north_high  = csr_wdata;
            CSR_A_EAST_LOW:  cfg_in.a_east_low  = csr_wdata;
            CSR_A_EAST_HIGH: cfg_in.a_east_high = csr_wdata;
            CSR_B_EAST_LOW:  cfg_in.b_east_low  = csr_wdata;
            CSR_B_EAST_HIGH: cfg_in.b_east_high = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.north_low   <= COORD_W'(6100000);
         cfg_ff.north_high  <= COORD_W'(7700000);
         cfg_ff.a_east_low  <= COORD_W'(1200000);
         cfg_ff.a_east_high <= COORD_W'(1900000);
         cfg_ff.b_east_low  <= COORD_W'(250000);
         cfg_ff.b_east_high <= COORD_W'(925000);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gctp_front #(
      .MAX_DIGITS (MAX_DIGITS),
      .ACC_W      (ACC_W)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .job_full (job_full),
      .job_push (job_push),
      .job_data (job_in_data)
   );

   gctp_queue #(
      .WIDTH (JOB_W),
      .DEPTH (2)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in_data),
      .pop       (job_pop),
      .pop_data  (job_out_data),
      .full      (job_full),
      .empty     (job_empty)
   );

   gctp_back #(
      .ACC_W (ACC_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_empty (job_empty),
      .job_data  (job_out_data),
      .job_pop   (job_pop),
      .rsp       (rsp_ch)
   );

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for grid_coordinate_text_parser: feeds coordinate texts a
// character at a time, predicts every result and compares it word by word.
// Depends on gctp_pkg, gctp_req_if/gctp_rsp_if and the parser RTL.
module tb_top;
   import gctp_pkg::*;

   localparam int unsigned TEXT_MAX_DIGITS = 7;
   localparam int unsigned COORD_MAX       = 9999999;
   localparam int unsigned SETTLE_CYCLES   = 16;
   localparam int unsigned HOLD_OFF_CYCLES = 250;
   localparam int unsigned CYCLE_LIMIT     = 400000;
   localparam int unsigned N_DIRECTED      = 25;

   typedef enum logic [2:0] {
      SCAN_LEAD, SCAN_NORTH, SCAN_GAP, SCAN_EAST, SCAN_TRAIL
   } scan_phase_type;

   typedef struct packed {
      status_type         status;
      logic [COORD_W-1:0] north;
      logic [COORD_W-1:0] east;
      logic [RES_W-1:0]   res;
   } grid_fix_type;

   typedef struct {
      string        text;
      bit           typed;
      grid_fix_type fix;
   } directed_text_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_wr_en;
   logic [2:0]         csr_index;
   logic [COORD_W-1:0] csr_wdata;

   gctp_req_if req_bus ();
   gctp_rsp_if rsp_bus ();

   grid_coordinate_text_parser #(.MAX_DIGITS(TEXT_MAX_DIGITS)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // Shadow of the parser: scan state and range bounds
   scan_phase_type     scan_ph;
   int unsigned        run_len;
   longint unsigned    north_sum, east_sum;
   logic               text_bad;
   logic [COORD_W-1:0] lim [6];

   grid_fix_type pending_fixes [$];
   grid_fix_type want;
   logic [7:0]   text_buf [$];
   logic         typed_pending;
   grid_fix_type typed_fix;
   logic         idling_on;
   logic         hold_off_req;
   int unsigned mismatches   = 0;
   int unsigned results_seen = 0;
   int unsigned chars_taken  = 0;
   int unsigned n_ok = 0, n_syntax = 0, n_range = 0, n_settings = 0;
   int unsigned cycle_count  = 0;

   // Expected words are typed in only where they follow at once from the
   // reset bounds; the other rows go through the shadow parser.
   directed_text_type directed_rows [N_DIRECTED] = '{
      '{"6500000 1500000", 1'b1, '{STATUS_OK, 24'd6500000, 24'd1500000, 10'd5}},
      '{"\011\0126500000\013\0141500000\015 ", 1'b0, '{STATUS_OK, 24'd0, 24'd0, 10'd0}},
      '{"6500 1500", 1'b1, '{STATUS_OK, 24'd6500000, 24'd1500000, 10'd1000}},
      '{"68000 5000", 1'b1, '{STATUS_RANGE, 24'd0, 24'd0, 10'd100}},
      '{"6800000 0500000", 1'b1, '{STATUS_OK, 24'd6800000, 24'd500000, 10'd5}},
      '{"6800000 500000", 1'b0, '{STATUS_OK, 24'd0, 24'd0, 10'd0}},
      '{"6100000 1200000", 1'b1, '{STATUS_OK, 24'd6100000, 24'd1200000, 10'd5}},
      '{"7700000 1200000", 1'b1, '{STATUS_RANGE, 24'd0, 24'd0, 10'd5}},
      '{"6100000 1900000", 1'b1, '{STATUS_RANGE, 24'd0, 24'd0, 10'd5}},
      '{"6099999 1899999", 1'b1, '{STATUS_RANGE, 24'd0, 24'd0, 10'd5}},
      '{"0001 0001", 1'b1, '{STATUS_RANGE, 24'd0, 24'd0, 10'd1023}},
      '{"0000 1234", 1'b1, '{STATUS_SYNTAX, 24'd0, 24'd0, 10'd1}},
      '{"650 150", 1'b1, '{STATUS_SYNTAX, 24'd0, 24'd0, 10'd1}},
      '{"65000000 1500000", 1'b1, '{STATUS_SYNTAX, 24'd0, 24'd0, 10'd1}},
      '{"6500000 15000000", 1'b1, '{STATUS_SYNTAX, 24'd0, 24'd0, 10'd1}},
      '{"6500000 1500000x", 1'b1, '{STATUS_SYNTAX, 24'd0, 24'd0, 10'd1}},
      '{"x6500000 1500000", 1'b1, '{STATUS_SYNTAX, 24'd0, 24'd0, 10'd1}},
      '{"65\3770000 1500000", 1'b1, '{STATUS_SYNTAX, 24'd0, 24'd0, 10'd1}},
      '{"5", 1'b1, '{STATUS_SYNTAX, 24'd0, 24'd0, 10'd1}},
      '{" ", 1'b1, '{STATUS_SYNTAX, 24'd0, 24'd0, 10'd1}},
      '{"6500000", 1'b1, '{STATUS_SYNTAX, 24'd0, 24'd0, 10'd1}},
      '{"6500000 ", 1'b1, '{STATUS_SYNTAX, 24'd0, 24'd0, 10'd1}},
      '{"6500000 150", 1'b1, '{STATUS_SYNTAX, 24'd0, 24'd0, 10'd1}},
      '{"9999999 9999999", 1'b1, '{STATUS_RANGE, 24'd0, 24'd0, 10'd5}},
      '{"0765432 0123456", 1'b0, '{STATUS_OK, 24'd0, 24'd0, 10'd0}}
   };

   function automatic logic in_span(input longint unsigned lo, v, hi);
      return lo <= v && v < hi;
   endfunction

   task automatic clear_scan();
      scan_ph  = SCAN_LEAD;
      run_len  = 0;
      north_sum = 0;
      east_sum = 0;
      text_bad = 1'b0;
   endtask

   task automatic take_digit(input int unsigned d);
      if (run_len >= TEXT_MAX_DIGITS) begin
         text_bad = 1'b1;
      end else begin
         if (scan_ph == SCAN_NORTH) north_sum = north_sum * 10 + d;
         else east_sum = east_sum * 10 + d;
         run_len++;
      end
   endtask

   // Advance the shadow parser by one character; on the final one build the word.
   task automatic scan_char(input logic [7:0] c, input logic fin,
                            output logic produced, output grid_fix_type fix);
      logic            ws, dg, ok, fits;
      longint unsigned n, e, factor;
      int unsigned     steps;
      ws = (c >= CHAR_TAB && c <= CHAR_CR) || c == CHAR_SPACE;
      dg = c >= CHAR_ZERO && c <= CHAR_NINE;
      fix = '0;
      if (!text_bad) begin
         case (scan_ph)
            SCAN_LEAD, SCAN_GAP: begin
               if (dg) begin
                  scan_ph = (scan_ph == SCAN_LEAD) ? SCAN_NORTH : SCAN_EAST;
                  run_len = 0;
                  take_digit(c - CHAR_ZERO);
               end else if (!ws) begin
                  text_bad = 1'b1;
               end
            end
            SCAN_NORTH, SCAN_EAST: begin
               if (dg) take_digit(c - CHAR_ZERO);
               else if (ws && run_len >= MIN_DIGITS)
                  scan_ph = (scan_ph == SCAN_NORTH) ? SCAN_GAP : SCAN_TRAIL;
               else text_bad = 1'b1;
            end
            default: begin
               if (!ws) text_bad = 1'b1;
            end
         endcase
      end
      produced = fin;
      if (fin) begin
         ok = !text_bad && north_sum != 0 &&
              ((scan_ph == SCAN_EAST && run_len >= MIN_DIGITS) || scan_ph == SCAN_TRAIL);
         if (!ok) begin
            fix = '{STATUS_SYNTAX, '0, '0, RES_W'(1)};
         end else begin
            n = north_sum;
            e = east_sum;
            factor = 1;
            steps = 0;
            while (n < SCALE_TARGET) begin
               n *= 10;
               e *= 10;
               factor *= 10;
               steps++;
            end
            fits = in_span(lim[CSR_NORTH_LOW], n, lim[CSR_NORTH_HIGH]) &&
                   (in_span(lim[CSR_A_EAST_LOW], e, lim[CSR_A_EAST_HIGH]) ||
                    (steps == 0 && in_span(lim[CSR_B_EAST_LOW], e, lim[CSR_B_EAST_HIGH])));
            fix.status = fits ? STATUS_OK : STATUS_RANGE;
            fix.north  = fits ? n[COORD_W-1:0] : '0;
            fix.east   = fits ? e[COORD_W-1:0] : '0;
            if (steps == 0) fix.res = RES_W'(5);
            else if (factor > 1000) fix.res = RES_W'(1023);
            else fix.res = RES_W'(factor);
         end
         clear_scan();
      end
   endtask

   // Offer one character, wait for the handshake, then predict.
   task automatic send_char(input logic [7:0] c, input logic fin);
      logic         produced;
      grid_fix_type fix;
      while (idling_on && $urandom_range(0, 99) < 12) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.text_char <= c;
      req_bus.is_final  <= fin;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      if (!text_bad) chars_taken++;
      scan_char(c, fin, produced, fix);
      if (produced) begin
         if (typed_pending) fix = typed_fix;
         typed_pending = 1'b0;
         pending_fixes.push_back(fix);
         case (fix.status)
            STATUS_OK:     n_ok++;
            STATUS_SYNTAX: n_syntax++;
            default:       n_range++;
         endcase
      end
   endtask

   task automatic send_text();
      foreach (text_buf[i]) send_char(text_buf[i], i == text_buf.size() - 1);
   endtask

   // Drop valid, wait for every outstanding word, then let the back end go quiet.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (pending_fixes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_bounds(input int unsigned nl, nh, al, ah, bl, bh);
      csr_index_type      order [6];
      logic [COORD_W-1:0] vals [6];
      order = '{CSR_NORTH_LOW, CSR_NORTH_HIGH, CSR_A_EAST_LOW, CSR_A_EAST_HIGH,
                CSR_B_EAST_LOW, CSR_B_EAST_HIGH};
      vals  = '{COORD_W'(nl), COORD_W'(nh), COORD_W'(al), COORD_W'(ah),
                COORD_W'(bl), COORD_W'(bh)};
      foreach (order[i]) begin
         csr_wr_en <= 1'b1;
         csr_index <= order[i];
         csr_wdata <= vals[i];
         @(posedge clock);
         lim[order[i]] = vals[i];
      end
      csr_wr_en <= 1'b0;
      n_settings++;
   endtask

   task automatic random_bounds();
      int unsigned nl, al, bl;
      nl = $urandom_range(0, 7000000);
      al = $urandom_range(0, 8000000);
      bl = $urandom_range(0, 900000);
      apply_bounds(nl, $urandom_range(nl, COORD_MAX), al, $urandom_range(al, COORD_MAX),
                   bl, $urandom_range(bl, COORD_MAX));
   endtask

   function automatic logic [7:0] ws_char();
      int unsigned k;
      k = $urandom_range(0, 5);
      return (k == 5) ? CHAR_SPACE : CHAR_TAB + 8'(k);
   endfunction

   // Pick a value around a bound pair so that both hits and near misses occur.
   function automatic logic [COORD_W-1:0] near_span(input logic [COORD_W-1:0] lo, hi);
      int unsigned a, b;
      a = (lo < hi) ? lo : hi;
      b = (lo < hi) ? hi : lo;
      a = (a > 20000) ? a - 20000 : 0;
      b = (b + 20000 > COORD_MAX) ? COORD_MAX : b + 20000;
      return COORD_W'($urandom_range(a, b));
   endfunction

   // Append the leading count digits of v written with seven digits.
   task automatic put_digits(input logic [COORD_W-1:0] v, input int unsigned count);
      int unsigned p;
      p = 1000000;
      repeat (count) begin
         text_buf.push_back(CHAR_ZERO + 8'((v / p) % 10));
         p /= 10;
      end
   endtask

   // Mostly well-formed texts aimed at the current bounds, some mutated, some noise.
   task automatic compose_text();
      int unsigned        kind, ndig, edig, k;
      logic [COORD_W-1:0] nv, ev;
      text_buf.delete();
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
         repeat ($urandom_range(1, 12)) begin
            if ($urandom_range(0, 1)) text_buf.push_back(8'($urandom_range(0, 255)));
            else if ($urandom_range(0, 1)) text_buf.push_back(ws_char());
            else text_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
         end
      end else begin
         repeat ($urandom_range(0, 2)) text_buf.push_back(ws_char());
         ndig = $urandom_range(0, 1) ? 7 : $urandom_range(4, 7);
         // leading zeros can push the scale factor past a thousand
         nv = ($urandom_range(0, 19) == 0) ? COORD_W'($urandom_range(0, 99999))
                                           : near_span(lim[CSR_NORTH_LOW], lim[CSR_NORTH_HIGH]);
         put_digits(nv, ndig);
         repeat ($urandom_range(1, 3)) text_buf.push_back(ws_char());
         ev = $urandom_range(0, 1) ? near_span(lim[CSR_A_EAST_LOW], lim[CSR_A_EAST_HIGH])
                                   : near_span(lim[CSR_B_EAST_LOW], lim[CSR_B_EAST_HIGH]);
         edig = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 7) : ndig;
         put_digits(ev, edig);
         repeat ($urandom_range(0, 2)) text_buf.push_back(ws_char());
         if (kind < 25) begin
            k = $urandom_range(0, text_buf.size() - 1);
            case ($urandom_range(0, 2))
               0:       text_buf[k] = 8'($urandom_range(0, 255));
               1:       text_buf.delete(k);
               default: text_buf.insert(k, CHAR_ZERO + 8'($urandom_range(0, 9)));
            endcase
         end
      end
   endtask

   task automatic run_texts(input int unsigned budget);
      int unsigned start;
      start = chars_taken;
      while (chars_taken - start < budget) begin
         compose_text();
         send_text();
      end
   endtask

   task automatic note_mismatch(input string what, input logic [31:0] exp_v, got_v);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: word %0d %s: expected %0d, got %0d",
                  $time, results_seen, what, exp_v, got_v);
   endtask

   // Result receiver: random stalls, plus one long hold-off on request
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold_off_req) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end else begin
            rsp_bus.ready <= !(idling_on && $urandom_range(0, 99) < 12);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         results_seen++;
         if (pending_fixes.size() == 0) begin
            note_mismatch("arrived with nothing expected, status", '0, rsp_bus.status);
         end else begin
            want = pending_fixes.pop_front();
            if (rsp_bus.status !== want.status)
               note_mismatch("status", want.status, rsp_bus.status);
            if (rsp_bus.north_out !== want.north)
               note_mismatch("north_out", want.north, rsp_bus.north_out);
            if (rsp_bus.east_out !== want.east)
               note_mismatch("east_out", want.east, rsp_bus.east_out);
            if (rsp_bus.resolution_out !== want.res)
               note_mismatch("resolution_out", want.res, rsp_bus.resolution_out);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Stopped at the cycle limit with %0d words outstanding",
                  pending_fixes.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.text_char <= '0;
      req_bus.is_final  <= 1'b0;
      csr_wr_en         <= 1'b0;
      csr_index         <= CSR_NORTH_LOW;
      csr_wdata         <= '0;
      idling_on     = 1'b1;
      hold_off_req  = 1'b0;
      typed_pending = 1'b0;
      lim[CSR_NORTH_LOW]   = COORD_W'(6100000);
      lim[CSR_NORTH_HIGH]  = COORD_W'(7700000);
      lim[CSR_A_EAST_LOW]  = COORD_W'(1200000);
      lim[CSR_A_EAST_HIGH] = COORD_W'(1900000);
      lim[CSR_B_EAST_LOW]  = COORD_W'(250000);
      lim[CSR_B_EAST_HIGH] = COORD_W'(925000);
      clear_scan();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         text_buf.delete();
         for (int i = 0; i < directed_rows[r].text.len(); i++)
            text_buf.push_back(directed_rows[r].text[i]);
         typed_pending = directed_rows[r].typed;
         typed_fix     = directed_rows[r].fix;
         send_text();
      end
      settle();

      // wide open bounds, no idling on either side
      idling_on = 1'b0;
      apply_bounds(0, COORD_MAX, 0, COORD_MAX, 0, COORD_MAX);
      run_texts(300);
      settle();

      idling_on = 1'b1;
      random_bounds();
      run_texts(300);
      settle();

      // empty ranges: nothing can be accepted
      apply_bounds(COORD_MAX, 0, COORD_MAX, 0, COORD_MAX, 0);
      run_texts(200);
      settle();

      // back to the default bounds, with the receiver holding off first
      apply_bounds(6100000, 7700000, 1200000, 1900000, 250000, 925000);
      hold_off_req = 1'b1;
      run_texts(400);
      settle();

      random_bounds();
      run_texts(300);
      settle();

      $display("Covered %0d texts: %0d accepted, %0d syntax errors, %0d outside the grids",
               n_ok + n_syntax + n_range, n_ok, n_syntax, n_range);
      $display("%0d characters parsed, %0d words compared, %0d bound settings, %0d mismatches",
               chars_taken, results_seen, n_settings, mismatches);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
